// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the buddy allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion, sampled on the rising clock edge, off while in reset.
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bba_pkg.sv
// Types, constants and tree index helpers shared by the buddy allocator modules.
`default_nettype none

package bba_pkg;

  localparam int unsigned POOL_LOG2      = 16;
  localparam int unsigned MIN_BLOCK_LOG2 = 6;
  localparam int unsigned LEVELS         = POOL_LOG2 - MIN_BLOCK_LOG2 + 1;
  localparam int unsigned NODES          = (2 ** LEVELS) - 1;
  localparam int unsigned IDX_W          = LEVELS;
  localparam int unsigned LVL_W          = $clog2(LEVELS + 1);
  localparam int unsigned SH_W           = $clog2(POOL_LOG2 + 1);
  localparam int unsigned REQ_W          = 17;
  localparam int unsigned OFF_W          = 16;
  localparam int unsigned USED_W         = POOL_LOG2 + 1;
  localparam int unsigned STAT_W         = 3;

  localparam logic [USED_W-1:0] POOL_SIZE = USED_W'(1) << POOL_LOG2;

  typedef enum logic [1:0] {
    NODE_FREE  = 2'd0,
    NODE_ALLOC = 2'd1,
    NODE_SPLIT = 2'd2
  } node_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_LARGE = 3'd1,
    STAT_NO_MEM    = 3'd2,
    STAT_NO_SLOT   = 3'd3,
    STAT_OUTSIDE   = 3'd4,
    STAT_NOT_ALLOC = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    W_IDLE,
    W_A_VISIT,
    W_A_ASCEND,
    W_A_MARK,
    W_F_LOOK,
    W_F_WRITE,
    W_F_MERGE,
    W_DONE
  } walk_state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    node_e            wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e           status;
    logic [OFF_W-1:0]  offset;
    logic [USED_W-1:0] used;
  } result_t;

  function automatic logic [IDX_W-1:0] node_parent(input logic [IDX_W-1:0] idx);
    return (idx - IDX_W'(1)) >> 1;
  endfunction

  function automatic logic [IDX_W-1:0] node_buddy(input logic [IDX_W-1:0] idx);
    return idx[0] ? idx + IDX_W'(1) : idx - IDX_W'(1);
  endfunction

  function automatic logic [USED_W-1:0] level_bytes(input logic [LVL_W-1:0] lvl);
    return POOL_SIZE >> lvl;
  endfunction

  function automatic logic [IDX_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
    return ~({IDX_W{1'b1}} << lvl);
  endfunction

  function automatic logic [SH_W-1:0] level_shift(input logic [LVL_W-1:0] lvl);
    return SH_W'(POOL_LOG2) - SH_W'(lvl);
  endfunction

  // Deepest level whose block still holds the request.
  function automatic logic [LVL_W-1:0] fit_level(input logic [REQ_W-1:0] req);
    logic [LVL_W-1:0] t;
    t = '0;
    for (int l = 1; l < LEVELS; l++) begin
      if (level_bytes(LVL_W'(l)) >= USED_W'(req)) begin
        t = LVL_W'(l);
      end
    end
    return t;
  endfunction

  function automatic logic [IDX_W-1:0] free_cand(input logic [OFF_W-1:0] off,
                                                 input logic [LVL_W-1:0] lvl);
    return level_base(lvl) + IDX_W'(off >> level_shift(lvl));
  endfunction

  function automatic logic free_aligned(input logic [OFF_W-1:0] off,
                                        input logic [LVL_W-1:0] lvl);
    logic [USED_W-1:0] m;
    m = (USED_W'(1) << level_shift(lvl)) - USED_W'(1);
    return (USED_W'(off) & m) == '0;
  endfunction

  function automatic logic [OFF_W-1:0] alloc_offset(input logic [IDX_W-1:0] idx,
                                                    input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] k;
    k = idx - level_base(lvl);
    return OFF_W'(OFF_W'(k) << level_shift(lvl));
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bba_tree_ram.sv
// Node state memory of the buddy tree with its clearing sweep after reset.
`default_nettype none

module bba_tree_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bba_pkg::mem_req_t mem_req_i,
  output bba_pkg::node_e    rd_o,
  output logic              init_done_o
);
  import bba_pkg::*;

  node_e            node_mem_q [NODES];
  node_e            rd_q;
  logic             clr_busy_q, clr_busy_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  node_e            wr_data;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + IDX_W'(1);
      if (clr_cnt_q == IDX_W'(NODES - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  assign wr_en   = clr_busy_q || mem_req_i.we;
  assign wr_addr = clr_busy_q ? clr_cnt_q : mem_req_i.waddr;
  assign wr_data = clr_busy_q ? NODE_FREE : mem_req_i.wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      node_mem_q[wr_addr] <= wr_data;
    end
    rd_q <= node_mem_q[mem_req_i.raddr];
  end

  assign rd_o        = rd_q;
  assign init_done_o = !clr_busy_q;

endmodule

`default_nettype wire

// File: rtl/core/bba_walker.sv
// Sequencer that walks the buddy tree one node per cycle for allocate and free.
`default_nettype none

module bba_walker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       init_done_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [bba_pkg::REQ_W-1:0]  req_bytes_i,
  input  logic [bba_pkg::OFF_W-1:0]  free_offset_i,
  output bba_pkg::mem_req_t          mem_req_o,
  input  bba_pkg::node_e             rd_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output bba_pkg::result_t           res_o
);
  import bba_pkg::*;

  walk_state_e       state_q, state_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [LVL_W-1:0]  tgt_q, tgt_d;
  logic [OFF_W-1:0]  foff_q, foff_d;
  status_e           stat_q, stat_d;
  logic [OFF_W-1:0]  boff_q, boff_d;
  logic [USED_W-1:0] used_q, used_d;

  logic             accept;
  logic             req_too_large, req_no_mem, off_outside;
  logic             at_tgt, a_prune, a_found;
  logic             cur_root, cur_left, par_root;
  logic [IDX_W-1:0] cur_par, cur_child;
  logic             f_hit, last_lvl;
  logic             use_buddy;

  assign in_ready_o    = (state_q == W_IDLE) && init_done_i;
  assign accept        = in_valid_i && in_ready_o;
  assign req_too_large = USED_W'(req_bytes_i) > POOL_SIZE;
  assign req_no_mem    = USED_W'(req_bytes_i) > (POOL_SIZE - used_q);
  assign off_outside   = USED_W'(free_offset_i) >= POOL_SIZE;

  assign at_tgt    = lvl_q == tgt_q;
  assign a_prune   = (rd_i == NODE_ALLOC) || (at_tgt && (rd_i != NODE_FREE));
  assign a_found   = at_tgt && (rd_i == NODE_FREE);
  assign cur_root  = cur_q == '0;
  assign cur_left  = cur_q[0];
  assign cur_par   = node_parent(cur_q);
  assign par_root  = cur_par == '0;
  assign cur_child = {cur_q[IDX_W-2:0], 1'b1};
  assign f_hit     = free_aligned(foff_q, lvl_q) && (rd_i == NODE_ALLOC);
  assign last_lvl  = lvl_q == LVL_W'(LEVELS - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      W_IDLE: begin
        if (accept) begin
          if (!mode_i) begin
            state_d = (req_too_large || req_no_mem) ? W_DONE : W_A_VISIT;
          end else begin
            state_d = off_outside ? W_DONE : W_F_LOOK;
          end
        end
      end
      W_A_VISIT: begin
        if (a_prune) begin
          state_d = W_A_ASCEND;
        end else if (a_found) begin
          state_d = cur_root ? W_DONE : W_A_MARK;
        end
      end
      W_A_ASCEND: begin
        if (cur_root) begin
          state_d = W_DONE;
        end else if (cur_left) begin
          state_d = W_A_VISIT;
        end
      end
      W_A_MARK: begin
        if (par_root) begin
          state_d = W_DONE;
        end
      end
      W_F_LOOK: begin
        if (f_hit) begin
          state_d = W_F_WRITE;
        end else if (last_lvl) begin
          state_d = W_DONE;
        end
      end
      W_F_WRITE: begin
        state_d = cur_root ? W_DONE : W_F_MERGE;
      end
      W_F_MERGE: begin
        if ((rd_i != NODE_FREE) || par_root) begin
          state_d = W_DONE;
        end
      end
      W_DONE: begin
        if (res_ready_i) begin
          state_d = W_IDLE;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_comb begin
    cur_d           = cur_q;
    lvl_d           = lvl_q;
    tgt_d           = tgt_q;
    foff_d          = foff_q;
    stat_d          = stat_q;
    boff_d          = boff_q;
    used_d          = used_q;
    use_buddy       = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = cur_q;
    mem_req_o.wdata = NODE_FREE;
    case (state_q)
      W_IDLE: begin
        if (accept) begin
          cur_d  = '0;
          lvl_d  = '0;
          tgt_d  = fit_level(req_bytes_i);
          foff_d = free_offset_i;
          boff_d = '0;
          stat_d = STAT_OK;
          if (!mode_i) begin
            if (req_too_large) begin
              stat_d = STAT_TOO_LARGE;
            end else if (req_no_mem) begin
              stat_d = STAT_NO_MEM;
            end
          end else if (off_outside) begin
            stat_d = STAT_OUTSIDE;
          end
        end
      end
      W_A_VISIT: begin
        if (a_prune) begin
          cur_d = cur_q;
        end else if (a_found) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.wdata = NODE_ALLOC;
          used_d          = used_q + level_bytes(tgt_q);
          boff_d          = alloc_offset(cur_q, tgt_q);
        end else begin
          cur_d = cur_child;
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      W_A_ASCEND: begin
        if (cur_root) begin
          stat_d = STAT_NO_SLOT;
        end else if (cur_left) begin
          cur_d = cur_q + IDX_W'(1);
        end else begin
          cur_d = cur_par;
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      W_A_MARK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cur_par;
        mem_req_o.wdata = NODE_SPLIT;
        cur_d           = cur_par;
      end
      W_F_LOOK: begin
        if (f_hit) begin
          used_d = used_q - level_bytes(lvl_q);
        end else if (last_lvl) begin
          stat_d = STAT_NOT_ALLOC;
        end else begin
          lvl_d = lvl_q + LVL_W'(1);
          cur_d = free_cand(foff_q, lvl_q + LVL_W'(1));
        end
      end
      W_F_WRITE: begin
        mem_req_o.we = 1'b1;
        use_buddy    = 1'b1;
      end
      W_F_MERGE: begin
        if (rd_i == NODE_FREE) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cur_par;
          cur_d           = cur_par;
          use_buddy       = 1'b1;
        end
      end
      W_DONE: begin
        cur_d = cur_q;
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
    mem_req_o.raddr = use_buddy ? node_buddy(cur_d) : cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      cur_q   <= '0;
      lvl_q   <= '0;
      tgt_q   <= '0;
      foff_q  <= '0;
      stat_q  <= STAT_OK;
      boff_q  <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      lvl_q   <= lvl_d;
      tgt_q   <= tgt_d;
      foff_q  <= foff_d;
      stat_q  <= stat_d;
      boff_q  <= boff_d;
      used_q  <= used_d;
    end
  end

  assign res_valid_o   = state_q == W_DONE;
  assign res_o.status  = stat_q;
  assign res_o.offset  = boff_q;
  assign res_o.used    = used_q;

endmodule

`default_nettype wire

// File: rtl/core/buddy_block_allocator.sv
// Allocate takes one step per node visited, per backtrack step and per ancestor marked;
// fragmentation lengthens it, since more nodes are visited and more backtrack steps taken.
// Free takes one step per level probed and one per buddy checked.
// Reset empties the output beat and zeroes the used count, then a sweep writes all 2047
// nodes free, one per cycle, with in_ready_o low until the sweep is done.
`default_nettype none

module buddy_block_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [bba_pkg::REQ_W-1:0]   req_bytes_i,
  input  logic [bba_pkg::OFF_W-1:0]   free_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bba_pkg::STAT_W-1:0]  status_o,
  output logic [bba_pkg::OFF_W-1:0]   block_offset_o,
  output logic [bba_pkg::USED_W-1:0]  used_bytes_o
);
  import bba_pkg::*;

  mem_req_t mem_req;
  node_e    rd_data;
  logic     init_done;
  logic     res_valid, res_ready, res_fire;
  result_t  res;
  result_t  out_res_q;
  logic     out_valid_q, out_valid_d;

  bba_tree_ram u_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_req_i   (mem_req),
    .rd_o        (rd_data),
    .init_done_o (init_done)
  );

  bba_walker u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .init_done_i   (init_done),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .req_bytes_i   (req_bytes_i),
    .free_offset_i (free_offset_i),
    .mem_req_o     (mem_req),
    .rd_i          (rd_data),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  assign res_ready   = !out_valid_q || out_ready_i;
  assign res_fire    = res_valid && res_ready;
  assign out_valid_d = res_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign block_offset_o = out_res_q.offset;
  assign used_bytes_o   = out_res_q.used;

endmodule

`default_nettype wire

// File: rtl/core/bba_checker.sv
// Port-level assertions for the buddy allocator and the bind that attaches them.
`default_nettype none
`include "assert_macros.svh"

module bba_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [bba_pkg::STAT_W-1:0]  status_o,
  input logic [bba_pkg::OFF_W-1:0]   block_offset_o,
  input logic [bba_pkg::USED_W-1:0]  used_bytes_o
);
  import bba_pkg::*;

  `BBA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(block_offset_o) && $stable(used_bytes_o), "stalled result beat changed")
  `BBA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready held high after a request was taken")
  `BBA_ASSERT(a_offset_zero, clk_i, rst_ni, (out_valid_o && (status_o != STAT_OK)) |-> (block_offset_o == '0), "offset not zero on a failed request")
  `BBA_ASSERT(a_used_bound, clk_i, rst_ni, out_valid_o |-> (used_bytes_o <= POOL_SIZE), "used byte count beyond the pool size")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .block_offset_o (block_offset_o),
  .used_bytes_o   (used_bytes_o)
);

`default_nettype wire
